// ===== rtl/ldpg_pkg.sv =====
package ldpg_pkg;

   localparam int HEIGHT_W   = 16;
   localparam int RUN_W      = 13;
   localparam int CFG_W      = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic             REG_ROWS   = 1'b0;
   localparam logic             REG_COLS   = 1'b1;
   localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
   localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

   typedef enum logic [1:0] {
      TOP_LOAD,
      TOP_RUN,
      TOP_EMIT
   } top_state_type;

   typedef enum logic [1:0] {
      SW_IDLE,
      SW_CLEAR,
      SW_CELL
   } sweep_state_type;

endpackage

// ===== rtl/longest_descent_path_grid.sv =====
// Load: one height word per cycle, req_stall low while loading.
// After the word marked last: a clearing pass over all rows*cols cells of the step memory,
// then sweeps over every cell (one memory read per neighbor slot), alternating direction
// until one changes nothing; the emit state then registers the result word valid as
// loading resumes (later while an earlier result word is stalled).
// Reset (synchronous): control, output valid and grid size (64 by 64) reset; heights do not.
module longest_descent_path_grid #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 64,
   parameter int HEIGHT_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [ldpg_pkg::HEIGHT_W-1:0]    req_height,
   input  logic                                    req_last_cell,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [ldpg_pkg::RUN_W-1:0]              rsp_run_length,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [ldpg_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [ldpg_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [ldpg_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                    csr_pready
);

   import ldpg_pkg::*;

   localparam int CELL_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W     = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
   localparam int CNT_W      = ADDR_W + 1;
   localparam int ROW_W      = $clog2(MAX_ROWS + 1);
   localparam int COL_W      = $clog2(MAX_COLS + 1);
   localparam int HB         = (HEIGHT_BITS < HEIGHT_W) ? HEIGHT_BITS : HEIGHT_W;

   top_state_type       state_ff, state_in;
   logic [CFG_W-1:0]    grid_rows_ff, grid_rows_in;
   logic [CFG_W-1:0]    grid_cols_ff, grid_cols_in;
   logic [CNT_W-1:0]    load_idx_ff, load_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RUN_W-1:0]    rsp_run_length_ff, rsp_run_length_in;

   logic [ROW_W-1:0]    rows_eff;
   logic [COL_W-1:0]    cols_eff;
   logic [CNT_W-1:0]    cell_count;
   logic [ADDR_W-1:0]   load_ptr;
   logic                req_accept;
   logic                csr_write;
   logic                sweep_start;
   logic                sweep_done;
   logic [ADDR_W-1:0]   sweep_best;
   logic [ADDR_W-1:0]   rd_addr;
   logic [HB-1:0]       h_rd_data;
   logic [ADDR_W-1:0]   s_rd_data;
   logic                s_wr_en;
   logic [ADDR_W-1:0]   s_wr_addr;
   logic [ADDR_W-1:0]   s_wr_data;

   always_comb begin
      if (grid_rows_ff == '0) begin
         rows_eff = ROW_W'(1);
      end else if (32'(grid_rows_ff) > 32'(MAX_ROWS)) begin
         rows_eff = ROW_W'(MAX_ROWS);
      end else begin
         rows_eff = ROW_W'(grid_rows_ff);
      end
      if (grid_cols_ff == '0) begin
         cols_eff = COL_W'(1);
      end else if (32'(grid_cols_ff) > 32'(MAX_COLS)) begin
         cols_eff = COL_W'(MAX_COLS);
      end else begin
         cols_eff = COL_W'(grid_cols_ff);
      end
   end

   assign cell_count = CNT_W'(CNT_W'(rows_eff) * CNT_W'(cols_eff));
   assign load_ptr   = (load_idx_ff >= cell_count) ? '0 : load_idx_ff[ADDR_W-1:0];
   assign req_stall  = (state_ff != TOP_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign sweep_start = req_accept && req_last_cell;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_COLS) ? CSR_DATA_W'(grid_cols_ff)
                                                  : CSR_DATA_W'(grid_rows_ff);

   ldpg_ram #(
      .WIDTH (HB),
      .DEPTH (CELL_DEPTH)
   ) u_height_ram (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (load_ptr),
      .wr_data (req_height[HB-1:0]),
      .rd_addr (rd_addr),
      .rd_data (h_rd_data)
   );

   ldpg_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (CELL_DEPTH)
   ) u_step_ram (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data),
      .rd_addr (rd_addr),
      .rd_data (s_rd_data)
   );

   ldpg_sweep #(
      .ROW_W  (ROW_W),
      .COL_W  (COL_W),
      .ADDR_W (ADDR_W),
      .HB     (HB)
   ) u_sweep (
      .clock      (clock),
      .reset      (reset),
      .start      (sweep_start),
      .rows       (rows_eff),
      .cols       (cols_eff),
      .cell_count (cell_count),
      .rd_addr    (rd_addr),
      .h_rd_data  (h_rd_data),
      .s_rd_data  (s_rd_data),
      .s_wr_en    (s_wr_en),
      .s_wr_addr  (s_wr_addr),
      .s_wr_data  (s_wr_data),
      .done       (sweep_done),
      .best       (sweep_best)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_LOAD;
         grid_rows_ff <= ROWS_RESET;
         grid_cols_ff <= COLS_RESET;
         load_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         load_idx_ff  <= load_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_run_length_ff <= rsp_run_length_in;
   end

   always_comb begin
      state_in          = state_ff;
      grid_rows_in      = grid_rows_ff;
      grid_cols_in      = grid_cols_ff;
      load_idx_in       = load_idx_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_run_length_in = rsp_run_length_ff;
      if (csr_write) begin
         if (csr_paddr[2] == REG_COLS) begin
            grid_cols_in = csr_pwdata[CFG_W-1:0];
         end else begin
            grid_rows_in = csr_pwdata[CFG_W-1:0];
         end
      end
      case (state_ff)
         TOP_LOAD: begin
            if (req_accept) begin
               if (req_last_cell) begin
                  load_idx_in = '0;
                  state_in    = TOP_RUN;
               end else begin
                  load_idx_in = CNT_W'(load_ptr) + CNT_W'(1);
               end
            end
         end
         TOP_RUN: begin
            if (sweep_done) begin
               state_in = TOP_EMIT;
            end
         end
         TOP_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_run_length_in = RUN_W'(CNT_W'(sweep_best) + CNT_W'(1));
               state_in          = TOP_LOAD;
            end
         end
         default: begin
            state_in = TOP_LOAD;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_run_length = rsp_run_length_ff;

   a_emit_after_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == TOP_EMIT)
      else $error("result word raised outside emit");

   a_load_in_grid: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> CNT_W'(load_ptr) < cell_count)
      else $error("height write outside grid");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_run_length_ff))
      else $error("stalled result word changed");

endmodule

// ===== rtl/ldpg_ram.sv =====
module ldpg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ldpg_step_unit.sv =====
module ldpg_step_unit #(
   parameter int HB     = 16,
   parameter int STEP_W = 12
) (
   input  logic              [STEP_W-1:0] acc,
   input  logic signed       [HB-1:0]     self_h,
   input  logic signed       [HB-1:0]     nb_h,
   input  logic              [STEP_W-1:0] nb_step,
   input  logic                           nb_ok,
   output logic              [STEP_W-1:0] acc_next
);

   logic [STEP_W-1:0] cand;

   always_comb begin
      cand = nb_step + STEP_W'(1);
      if (nb_ok && (nb_h < self_h) && (cand > acc)) begin
         acc_next = cand;
      end else begin
         acc_next = acc;
      end
   end

endmodule

// ===== rtl/ldpg_sweep.sv =====
module ldpg_sweep #(
   parameter int ROW_W  = 7,
   parameter int COL_W  = 7,
   parameter int ADDR_W = 12,
   parameter int HB     = 16,
   localparam int CNT_W = ADDR_W + 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [ROW_W-1:0]         rows,
   input  logic [COL_W-1:0]         cols,
   input  logic [CNT_W-1:0]         cell_count,
   output logic [ADDR_W-1:0]        rd_addr,
   input  logic signed [HB-1:0]     h_rd_data,
   input  logic [ADDR_W-1:0]        s_rd_data,
   output logic                     s_wr_en,
   output logic [ADDR_W-1:0]        s_wr_addr,
   output logic [ADDR_W-1:0]        s_wr_data,
   output logic                     done,
   output logic [ADDR_W-1:0]        best
);

   import ldpg_pkg::*;

   localparam logic [2:0] PHASE_SELF  = 3'd0;
   localparam logic [2:0] PHASE_UP    = 3'd1;
   localparam logic [2:0] PHASE_DOWN  = 3'd2;
   localparam logic [2:0] PHASE_LEFT  = 3'd3;
   localparam logic [2:0] PHASE_RIGHT = 3'd4;
   localparam logic [2:0] PHASE_LAST  = 3'd5;

   sweep_state_type          state_ff, state_in;
   logic [2:0]               phase_ff, phase_in;
   logic [ADDR_W-1:0]        pos_ff, pos_in;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic [COL_W-1:0]         col_ff, col_in;
   logic                     back_ff, back_in;
   logic                     changed_ff, changed_in;
   logic signed [HB-1:0]     hc_ff, hc_in;
   logic [ADDR_W-1:0]        acc_ff, acc_in;
   logic [ADDR_W-1:0]        old_ff, old_in;
   logic [ADDR_W-1:0]        sweep_best_ff, sweep_best_in;
   logic [ADDR_W-1:0]        best_ff, best_in;

   logic                     up_ok, down_ok, left_ok, right_ok;
   logic                     data_ok;
   logic [ADDR_W-1:0]        cols_a;
   logic [ADDR_W-1:0]        acc_step;
   logic                     sweep_end;
   logic                     fwd_end;
   logic                     changed_now;
   logic [ADDR_W-1:0]        best_now;

   assign up_ok    = (row_ff != '0);
   assign down_ok  = ((row_ff + ROW_W'(1)) < rows);
   assign left_ok  = (col_ff != '0);
   assign right_ok = ((col_ff + COL_W'(1)) < cols);
   assign cols_a   = ADDR_W'(cols);
   assign fwd_end  = ((CNT_W'(pos_ff) + CNT_W'(1)) == cell_count);
   assign sweep_end = back_ff ? (pos_ff == '0) : fwd_end;

   always_comb begin
      rd_addr = pos_ff;
      case (phase_ff)
         PHASE_UP:    if (up_ok)    rd_addr = pos_ff - cols_a;
         PHASE_DOWN:  if (down_ok)  rd_addr = pos_ff + cols_a;
         PHASE_LEFT:  if (left_ok)  rd_addr = pos_ff - ADDR_W'(1);
         PHASE_RIGHT: if (right_ok) rd_addr = pos_ff + ADDR_W'(1);
         default:     rd_addr = pos_ff;
      endcase
   end

   always_comb begin
      case (phase_ff)
         PHASE_DOWN:  data_ok = up_ok;
         PHASE_LEFT:  data_ok = down_ok;
         PHASE_RIGHT: data_ok = left_ok;
         PHASE_LAST:  data_ok = right_ok;
         default:     data_ok = 1'b0;
      endcase
   end

   ldpg_step_unit #(
      .HB     (HB),
      .STEP_W (ADDR_W)
   ) u_step (
      .acc      (acc_ff),
      .self_h   (hc_ff),
      .nb_h     (h_rd_data),
      .nb_step  (s_rd_data),
      .nb_ok    (data_ok),
      .acc_next (acc_step)
   );

   assign changed_now = changed_ff || (acc_step != old_ff);
   assign best_now    = (acc_step > sweep_best_ff) ? acc_step : sweep_best_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SW_IDLE;
         phase_ff <= PHASE_SELF;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
      pos_ff        <= pos_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      back_ff       <= back_in;
      changed_ff    <= changed_in;
      hc_ff         <= hc_in;
      acc_ff        <= acc_in;
      old_ff        <= old_in;
      sweep_best_ff <= sweep_best_in;
      best_ff       <= best_in;
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      back_in       = back_ff;
      changed_in    = changed_ff;
      hc_in         = hc_ff;
      acc_in        = acc_ff;
      old_in        = old_ff;
      sweep_best_in = sweep_best_ff;
      best_in       = best_ff;
      s_wr_en       = 1'b0;
      s_wr_addr     = pos_ff;
      s_wr_data     = '0;
      done          = 1'b0;
      case (state_ff)
         SW_IDLE: begin
            if (start) begin
               pos_in   = '0;
               state_in = SW_CLEAR;
            end
         end
         SW_CLEAR: begin
            s_wr_en = 1'b1;
            if (fwd_end) begin
               pos_in        = '0;
               row_in        = '0;
               col_in        = '0;
               back_in       = 1'b0;
               changed_in    = 1'b0;
               sweep_best_in = '0;
               phase_in      = PHASE_SELF;
               state_in      = SW_CELL;
            end else begin
               pos_in = pos_ff + ADDR_W'(1);
            end
         end
         SW_CELL: begin
            phase_in = phase_ff + 3'd1;
            if (phase_ff == PHASE_UP) begin
               hc_in  = h_rd_data;
               acc_in = s_rd_data;
               old_in = s_rd_data;
            end else if (phase_ff != PHASE_SELF && phase_ff != PHASE_LAST) begin
               acc_in = acc_step;
            end
            if (phase_ff == PHASE_LAST) begin
               s_wr_en   = 1'b1;
               s_wr_data = acc_step;
               phase_in  = PHASE_SELF;
               if (sweep_end) begin
                  if (!changed_now) begin
                     best_in  = best_now;
                     done     = 1'b1;
                     state_in = SW_IDLE;
                  end else begin
                     back_in       = !back_ff;
                     changed_in    = 1'b0;
                     sweep_best_in = '0;
                  end
               end else begin
                  changed_in    = changed_now;
                  sweep_best_in = best_now;
                  if (back_ff) begin
                     pos_in = pos_ff - ADDR_W'(1);
                     if (col_ff == '0) begin
                        col_in = cols - COL_W'(1);
                        row_in = row_ff - ROW_W'(1);
                     end else begin
                        col_in = col_ff - COL_W'(1);
                     end
                  end else begin
                     pos_in = pos_ff + ADDR_W'(1);
                     if (!right_ok) begin
                        col_in = '0;
                        row_in = row_ff + ROW_W'(1);
                     end else begin
                        col_in = col_ff + COL_W'(1);
                     end
                  end
               end
            end
         end
         default: begin
            state_in = SW_IDLE;
         end
      endcase
   end

   assign best = best_ff;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == SW_CELL |-> phase_ff <= PHASE_LAST)
      else $error("sweep phase out of range");

   a_write_in_grid: assert property (@(posedge clock) disable iff (reset)
      s_wr_en |-> CNT_W'(s_wr_addr) < cell_count)
      else $error("step write outside grid");

   a_pos_matches_rowcol: assert property (@(posedge clock) disable iff (reset)
      state_ff == SW_CELL |->
         CNT_W'(pos_ff) == CNT_W'(row_ff) * CNT_W'(cols) + CNT_W'(col_ff))
      else $error("position and row/column disagree");

endmodule
